FILE: rtl/hrhp_pkg.sv
// Shared types, codes and character-class helpers for the request header parser.
package hrhp_pkg;

  typedef enum logic [4:0] {
    PS_METHOD_START = 5'd0,
    PS_METHOD       = 5'd1,
    PS_URI          = 5'd2,
    PS_VER_H        = 5'd3,
    PS_VER_T1       = 5'd4,
    PS_VER_T2       = 5'd5,
    PS_VER_P        = 5'd6,
    PS_VER_SLASH    = 5'd7,
    PS_MAJOR_START  = 5'd8,
    PS_MAJOR        = 5'd9,
    PS_MINOR_START  = 5'd10,
    PS_MINOR        = 5'd11,
    PS_NL1          = 5'd12,
    PS_LINE_START   = 5'd13,
    PS_LWS          = 5'd14,
    PS_NAME         = 5'd15,
    PS_SPACE        = 5'd16,
    PS_VALUE        = 5'd17,
    PS_NL2          = 5'd18,
    PS_NL3          = 5'd19
  } parse_state_t;

  localparam logic [1:0] STAT_MORE   = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_DONE   = 2'd2;

  localparam logic [2:0] ROLE_NONE       = 3'd0;
  localparam logic [2:0] ROLE_METHOD     = 3'd1;
  localparam logic [2:0] ROLE_URI        = 3'd2;
  localparam logic [2:0] ROLE_NAME_START = 3'd3;
  localparam logic [2:0] ROLE_NAME       = 3'd4;
  localparam logic [2:0] ROLE_VALUE      = 3'd5;

  localparam logic [2:0] PM_FULL = 3'd4;
  localparam logic [2:0] PM_BAD  = 3'd7;

  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;

  // parser control state handed between top level and step logic
  typedef struct packed {
    parse_state_t pstate;
    logic         seen_header;
    logic [2:0]   post_match;
  } ctl_t;

  // per-item result tags
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] role;
  } tag_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_special(c);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // next letter of the word POST after n matched letters
  function automatic logic [7:0] post_letter(input logic [2:0] n);
    logic [7:0] r;
    case (n)
      3'd0: r = "P";
      3'd1: r = "O";
      3'd2: r = "S";
      3'd3: r = "T";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hrhp_step.sv
// Next-state and role/status logic for one request byte.
module hrhp_step
  import hrhp_pkg::*;
#(
  parameter int VERSION_BITS = 8
) (
  input  ctl_t                    cur,
  input  logic [VERSION_BITS-1:0] major_cur,
  input  logic [VERSION_BITS-1:0] minor_cur,
  input  logic                    op,
  input  logic [7:0]              data_byte,
  output ctl_t                    nxt,
  output logic [VERSION_BITS-1:0] major_next,
  output logic [VERSION_BITS-1:0] minor_next,
  output tag_t                    tag
);

  logic                    ok;
  logic [VERSION_BITS-1:0] major_dig;
  logic [VERSION_BITS-1:0] minor_dig;
  logic [2:0]              pm_adv;

  // acc*10 + digit, saturating
  function automatic logic [VERSION_BITS-1:0] add_digit(
    input logic [VERSION_BITS-1:0] acc,
    input logic [3:0]              dig
  );
    logic [VERSION_BITS+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VERSION_BITS{1'b0}}, dig};
    if (v[VERSION_BITS+3:VERSION_BITS] != 4'd0) begin
      return {VERSION_BITS{1'b1}};
    end
    return v[VERSION_BITS-1:0];
  endfunction

  assign major_dig = add_digit(major_cur, data_byte[3:0]);
  assign minor_dig = add_digit(minor_cur, data_byte[3:0]);
  assign pm_adv = ((cur.post_match < PM_FULL) && (data_byte == post_letter(cur.post_match)))
                  ? cur.post_match + 3'd1 : PM_BAD;

  always_comb begin
    nxt        = cur;
    major_next = major_cur;
    minor_next = minor_cur;
    tag.status = STAT_MORE;
    tag.role   = ROLE_NONE;
    ok         = 1'b1;
    if (op) begin
      nxt.pstate      = PS_METHOD_START;
      nxt.seen_header = 1'b0;
      nxt.post_match  = 3'd0;
      major_next      = '0;
      minor_next      = '0;
    end else begin
      case (cur.pstate)
        PS_METHOD_START: begin
          if (is_token(data_byte)) begin
            nxt.post_match = pm_adv;
            tag.role       = ROLE_METHOD;
            nxt.pstate     = PS_METHOD;
          end else ok = 1'b0;
        end
        PS_METHOD: begin
          if (data_byte == CH_SP) nxt.pstate = PS_URI;
          else if (is_token(data_byte)) begin
            nxt.post_match = pm_adv;
            tag.role       = ROLE_METHOD;
          end else ok = 1'b0;
        end
        PS_URI: begin
          if (data_byte == CH_SP) nxt.pstate = PS_VER_H;
          else if (is_ctl(data_byte)) ok = 1'b0;
          else tag.role = ROLE_URI;
        end
        PS_VER_H: begin
          if (data_byte == "H") nxt.pstate = PS_VER_T1; else ok = 1'b0;
        end
        PS_VER_T1: begin
          if (data_byte == "T") nxt.pstate = PS_VER_T2; else ok = 1'b0;
        end
        PS_VER_T2: begin
          if (data_byte == "T") nxt.pstate = PS_VER_P; else ok = 1'b0;
        end
        PS_VER_P: begin
          if (data_byte == "P") nxt.pstate = PS_VER_SLASH; else ok = 1'b0;
        end
        PS_VER_SLASH: begin
          if (data_byte == "/") begin
            major_next = '0;
            minor_next = '0;
            nxt.pstate = PS_MAJOR_START;
          end else ok = 1'b0;
        end
        PS_MAJOR_START: begin
          if (is_digit(data_byte)) begin
            major_next = major_dig;
            nxt.pstate = PS_MAJOR;
          end else ok = 1'b0;
        end
        PS_MAJOR: begin
          if (data_byte == ".") nxt.pstate = PS_MINOR_START;
          else if (is_digit(data_byte)) major_next = major_dig;
          else ok = 1'b0;
        end
        PS_MINOR_START: begin
          if (is_digit(data_byte)) begin
            minor_next = minor_dig;
            nxt.pstate = PS_MINOR;
          end else ok = 1'b0;
        end
        PS_MINOR: begin
          if (data_byte == CH_CR) nxt.pstate = PS_NL1;
          else if (is_digit(data_byte)) minor_next = minor_dig;
          else ok = 1'b0;
        end
        PS_NL1: begin
          if (data_byte == CH_LF) nxt.pstate = PS_LINE_START; else ok = 1'b0;
        end
        PS_LINE_START: begin
          if (data_byte == CH_CR) nxt.pstate = PS_NL3;
          else if (cur.seen_header && (data_byte == CH_SP || data_byte == CH_TAB)) begin
            nxt.pstate = PS_LWS;
          end else if (is_token(data_byte)) begin
            nxt.seen_header = 1'b1;
            tag.role        = ROLE_NAME_START;
            nxt.pstate      = PS_NAME;
          end else ok = 1'b0;
        end
        PS_LWS: begin
          if (data_byte == CH_CR) nxt.pstate = PS_NL2;
          else if (data_byte == CH_SP || data_byte == CH_TAB) nxt.pstate = PS_LWS;
          else if (is_ctl(data_byte)) ok = 1'b0;
          else begin
            tag.role   = ROLE_VALUE;
            nxt.pstate = PS_VALUE;
          end
        end
        PS_NAME: begin
          if (data_byte == ":") nxt.pstate = PS_SPACE;
          else if (is_token(data_byte)) tag.role = ROLE_NAME;
          else ok = 1'b0;
        end
        PS_SPACE: begin
          if (data_byte == CH_SP) nxt.pstate = PS_VALUE; else ok = 1'b0;
        end
        PS_VALUE: begin
          if (data_byte == CH_CR) nxt.pstate = PS_NL2;
          else if (is_ctl(data_byte)) ok = 1'b0;
          else tag.role = ROLE_VALUE;
        end
        PS_NL2: begin
          if (data_byte == CH_LF) nxt.pstate = PS_LINE_START; else ok = 1'b0;
        end
        PS_NL3: begin
          if (data_byte == CH_LF) tag.status = STAT_DONE; else ok = 1'b0;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      // a rejected byte leaves every piece of state alone
      if (!ok) begin
        nxt        = cur;
        major_next = major_cur;
        minor_next = minor_cur;
        tag.status = STAT_REJECT;
        tag.role   = ROLE_NONE;
      end
    end
  end

endmodule

FILE: rtl/http_request_header_parser_unit.sv
// Top level of the HTTP/1.1 request line and header parser.
//
// Input channel: in_valid / in_stall carry one item per transfer: op (0 = data
// byte, 1 = restart at method start) and data_byte. Output channel: out_valid /
// out_stall carry one result item per input item: status, byte_role, byte_out,
// is_post, major_version, minor_version.
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while out_stall is low; the parser state is a
// handful of flops set by each accepted byte, so byte N+1 sees byte N's state.
// The output register holds one item. While it is full and the receiver stalls,
// in_stall is raised; when the receiver takes it, a new item enters in the same
// cycle, so no bubble opens up.
// Reset (rst, synchronous) empties the output register and returns the parser
// to method start with versions, the POST tracker and the header flag cleared.
// A rejected byte reports status 1 and leaves all parser state as it was.
// VERSION_BITS sets the width of the saturating version counters; the version
// outputs show their low eight bits.
module http_request_header_parser_unit
  import hrhp_pkg::*;
#(
  parameter int VERSION_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [2:0] byte_role,
  output logic [7:0] byte_out,
  output logic       is_post,
  output logic [7:0] major_version,
  output logic [7:0] minor_version
);

  // parser state
  ctl_t                    ctl;
  ctl_t                    ctl_next;
  logic [VERSION_BITS-1:0] major_acc;
  logic [VERSION_BITS-1:0] minor_acc;
  logic [VERSION_BITS-1:0] major_acc_next;
  logic [VERSION_BITS-1:0] minor_acc_next;
  tag_t                    tag;

  // zero-extended views so narrow counters still fill the 8-bit outputs
  logic [VERSION_BITS+7:0] major_ext;
  logic [VERSION_BITS+7:0] minor_ext;

  logic accept;

  hrhp_step #(
    .VERSION_BITS(VERSION_BITS)
  ) u_step (
    .cur       (ctl),
    .major_cur (major_acc),
    .minor_cur (minor_acc),
    .op        (op),
    .data_byte (data_byte),
    .nxt       (ctl_next),
    .major_next(major_acc_next),
    .minor_next(minor_acc_next),
    .tag       (tag)
  );

  // output register is free when empty or being drained this cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign major_ext = {8'd0, major_acc_next};
  assign minor_ext = {8'd0, minor_acc_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.pstate      <= PS_METHOD_START;
      ctl.seen_header <= 1'b0;
      ctl.post_match  <= 3'd0;
      major_acc       <= '0;
      minor_acc       <= '0;
    end else if (accept) begin
      ctl       <= ctl_next;
      major_acc <= major_acc_next;
      minor_acc <= minor_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, taken along with the item
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= tag.status;
      byte_role     <= tag.role;
      byte_out      <= op ? 8'd0 : data_byte;
      is_post       <= (ctl_next.post_match == PM_FULL);
      major_version <= major_ext[7:0];
      minor_version <= minor_ext[7:0];
    end
  end

endmodule

FILE: tb/http_request_header_parser_unit_tb.sv
// Self-checking testbench for the HTTP request line and header parser unit.
`timescale 1ns / 100ps

module http_request_header_parser_unit_tb
  import hrhp_pkg::*;
();

  localparam int VER_BITS       = 8;
  localparam int VER_MAX        = (1 << VER_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 60;

  // one input item: restart flag plus request byte
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } req_item_t;

  // one result item as the parser should report it
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] role;
    logic [7:0] byte_out;
    logic       is_post;
    logic [7:0] major;
    logic [7:0] minor;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [2:0] byte_role;
  logic [7:0] byte_out;
  logic       is_post;
  logic [7:0] major_version;
  logic [7:0] minor_version;

  http_request_header_parser_unit #(
    .VERSION_BITS(VER_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .byte_role    (byte_role),
    .byte_out     (byte_out),
    .is_post      (is_post),
    .major_version(major_version),
    .minor_version(minor_version)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow state, updated once per accepted input item
  // ---------------------------------------------------------------------------
  parse_state_t ps = PS_METHOD_START;
  logic         hdr_seen = 1'b0;
  logic [7:0]   maj_num = 8'd0;
  logic [7:0]   min_num = 8'd0;
  logic [2:0]   post_hits = 3'd0;

  req_item_t     request_bytes_q[$];   // items waiting to be offered
  parse_result_t parse_results_q[$];   // results owed by the block, oldest first

  int send_idle_pct = 0;   // chance per cycle that the sender offers nothing
  int stall_pct     = 0;   // chance per cycle that the receiver stalls
  int items_added   = 0;
  int cut_left      = -1;  // bytes left before a request is cut short; -1 = no cut
  logic hold_req    = 1'b0; // toggled to ask the receiver for a long hold-off
  logic hold_ack    = 1'b0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  int error_count  = 0;
  int results_seen = 0;
  int done_seen    = 0;
  int reject_seen  = 0;
  int post_seen    = 0;
  int sat_seen     = 0;

  function automatic logic ctl_char(input logic [7:0] c);
    return (c < 8'd32) || (c == CH_DEL);
  endfunction

  function automatic logic token_char(input logic [7:0] c);
    string seps = "()<>@,;:\\\"/[]?={} ";
    if (c >= 8'd128 || ctl_char(c)) return 1'b0;
    foreach (seps[i]) if (seps[i] == c) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [2:0] post_next(input logic [2:0] n, input logic [7:0] c);
    string word = "POST";
    if (n < PM_FULL && c == word[n]) return n + 3'd1;
    return PM_BAD;
  endfunction

  // decimal digit appended, clamped at the counter's top value
  function automatic logic [7:0] version_push(input logic [7:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - 48;
    return (v > VER_MAX) ? VER_MAX[7:0] : v[7:0];
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Advance the shadow parser by one item and return the result it owes.
  // A rejected byte leaves every piece of state as it was.
  function automatic parse_result_t parse_byte(input logic restart, input logic [7:0] c);
    parse_result_t r;
    logic good;
    r = '0;
    good = 1'b1;
    r.byte_out = c;
    if (restart) begin
      ps = PS_METHOD_START;
      hdr_seen = 1'b0;
      maj_num = 8'd0;
      min_num = 8'd0;
      post_hits = 3'd0;
      r.byte_out = 8'd0;
    end else begin
      case (ps)
        PS_METHOD_START: begin
          if (token_char(c)) begin
            post_hits = post_next(post_hits, c);
            r.role = ROLE_METHOD;
            ps = PS_METHOD;
          end else good = 1'b0;
        end
        PS_METHOD: begin
          if (c == CH_SP) ps = PS_URI;
          else if (token_char(c)) begin
            post_hits = post_next(post_hits, c);
            r.role = ROLE_METHOD;
          end else good = 1'b0;
        end
        PS_URI: begin
          if (c == CH_SP) ps = PS_VER_H;
          else if (ctl_char(c)) good = 1'b0;
          else r.role = ROLE_URI;
        end
        PS_VER_H: begin
          if (c == "H") ps = PS_VER_T1; else good = 1'b0;
        end
        PS_VER_T1: begin
          if (c == "T") ps = PS_VER_T2; else good = 1'b0;
        end
        PS_VER_T2: begin
          if (c == "T") ps = PS_VER_P; else good = 1'b0;
        end
        PS_VER_P: begin
          if (c == "P") ps = PS_VER_SLASH; else good = 1'b0;
        end
        PS_VER_SLASH: begin
          if (c == "/") begin
            maj_num = 8'd0;
            min_num = 8'd0;
            ps = PS_MAJOR_START;
          end else good = 1'b0;
        end
        PS_MAJOR_START: begin
          if (digit_char(c)) begin
            maj_num = version_push(maj_num, c);
            ps = PS_MAJOR;
          end else good = 1'b0;
        end
        PS_MAJOR: begin
          if (c == ".") ps = PS_MINOR_START;
          else if (digit_char(c)) maj_num = version_push(maj_num, c);
          else good = 1'b0;
        end
        PS_MINOR_START: begin
          if (digit_char(c)) begin
            min_num = version_push(min_num, c);
            ps = PS_MINOR;
          end else good = 1'b0;
        end
        PS_MINOR: begin
          if (c == CH_CR) ps = PS_NL1;
          else if (digit_char(c)) min_num = version_push(min_num, c);
          else good = 1'b0;
        end
        PS_NL1: begin
          if (c == CH_LF) ps = PS_LINE_START; else good = 1'b0;
        end
        PS_LINE_START: begin
          // leading whitespace only continues a value once a header exists
          if (c == CH_CR) ps = PS_NL3;
          else if (hdr_seen && (c == CH_SP || c == CH_TAB)) ps = PS_LWS;
          else if (token_char(c)) begin
            hdr_seen = 1'b1;
            r.role = ROLE_NAME_START;
            ps = PS_NAME;
          end else good = 1'b0;
        end
        PS_LWS: begin
          if (c == CH_CR) ps = PS_NL2;
          else if (c == CH_SP || c == CH_TAB) begin
          end else if (ctl_char(c)) good = 1'b0;
          else begin
            r.role = ROLE_VALUE;
            ps = PS_VALUE;
          end
        end
        PS_NAME: begin
          if (c == ":") ps = PS_SPACE;
          else if (token_char(c)) r.role = ROLE_NAME;
          else good = 1'b0;
        end
        PS_SPACE: begin
          if (c == CH_SP) ps = PS_VALUE; else good = 1'b0;
        end
        PS_VALUE: begin
          if (c == CH_CR) ps = PS_NL2;
          else if (ctl_char(c)) good = 1'b0;
          else r.role = ROLE_VALUE;
        end
        PS_NL2: begin
          if (c == CH_LF) ps = PS_LINE_START; else good = 1'b0;
        end
        PS_NL3: begin
          // parser parks here: every further LF reports completion again
          if (c == CH_LF) r.status = STAT_DONE; else good = 1'b0;
        end
        default: good = 1'b0;
      endcase
      if (!good) begin
        r.status = STAT_REJECT;
        r.role = ROLE_NONE;
      end
    end
    r.is_post = (post_hits == PM_FULL);
    r.major = maj_num;
    r.minor = min_num;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic restart, input logic [7:0] c);
    req_item_t it;
    it.restart = restart;
    it.data = c;
    request_bytes_q.insert(request_bytes_q.size(), it);
    items_added++;
  endtask

  task automatic push_plain(input string s);
    foreach (s[i]) push_item(1'b0, s[i]);
  endtask

  // well-formed byte, with occasional noise or a stray restart slipped in ahead
  task automatic push_data(input logic [7:0] c);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    if ($urandom_range(99) < 4) push_item(1'b0, 8'($urandom_range(255)));
    if ($urandom_range(199) == 0) push_item(1'b1, 8'($urandom_range(255)));
    push_item(1'b0, c);
  endtask

  task automatic push_word(input string s);
    foreach (s[i]) push_data(s[i]);
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!token_char(c));
    return c;
  endfunction

  // printable or high byte; URIs cannot hold a space
  function automatic logic [7:0] rand_text(input logic allow_space);
    logic [7:0] c;
    do c = 8'($urandom_range(1) ? $urandom_range(32, 126) : $urandom_range(128, 255));
    while (!allow_space && c == CH_SP);
    return c;
  endfunction

  task automatic push_digits();
    int n;
    n = ($urandom_range(4) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
    repeat (n) push_data(8'("0" + $urandom_range(9)));
  endtask

  // One request: restart, request line, a few header lines, blank line.
  // Some are cut short so that the parser is left mid-line before the next restart.
  task automatic add_request();
    int sel;
    int nhdr;
    push_item(1'b1, 8'($urandom_range(255)));
    cut_left = ($urandom_range(7) == 0) ? $urandom_range(3, 30) : -1;
    sel = $urandom_range(9);
    if (sel < 4) push_word("POST");
    else if (sel == 4) begin
      push_word("POST");
      push_data(rand_token());
    end else if (sel == 5) push_word("POS");
    else repeat ($urandom_range(1, 6)) push_data(rand_token());
    push_data(CH_SP);
    repeat ($urandom_range(0, 8)) push_data(rand_text(1'b0));
    push_data(CH_SP);
    push_word("HTTP/");
    push_digits();
    push_data(".");
    push_digits();
    push_data(CH_CR);
    push_data(CH_LF);
    nhdr = $urandom_range(0, 3);
    repeat (nhdr) begin
      repeat ($urandom_range(1, 5)) push_data(rand_token());
      push_data(":");
      push_data(CH_SP);
      repeat ($urandom_range(0, 6)) push_data(rand_text(1'b1));
      push_data(CH_CR);
      push_data(CH_LF);
      if ($urandom_range(9) < 3) begin
        // folded continuation of the value
        repeat ($urandom_range(1, 2)) push_data($urandom_range(1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(0, 4)) push_data(rand_text(1'b1));
        push_data(CH_CR);
        push_data(CH_LF);
      end
    end
    push_data(CH_CR);
    push_data(CH_LF);
    cut_left = -1;
  endtask

  task automatic wait_drained();
    while (request_bytes_q.size() != 0 || in_valid || parse_results_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input logic hold);
    send_idle_pct = idle;
    stall_pct = stall;
    items_added = 0;
    if (hold) hold_req = ~hold_req;
    while (items_added < n) add_request();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued items, predicts each one at the edge that takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_results_q.insert(parse_results_q.size(), parse_byte(op, data_byte));
      end
      // a payload under stall stays put; otherwise pick the next item or idle
      if (!in_valid || !in_stall) begin
        if (request_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_bytes_q[0];
          request_bytes_q.delete(0);
          in_valid <= 1'b1;
          op <= nxt.restart;
          data_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request so the output
  // register fills and the block pushes back on its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (parse_results_q.size() == 0) begin
        $display("%0t ns: result with none owed, status %0d role %0d byte %0d",
                 $time, status, byte_role, byte_out);
        error_count++;
      end else begin
        want = parse_results_q[0];
        parse_results_q.delete(0);
        check_field("status", want.status, status);
        check_field("byte_role", want.role, byte_role);
        check_field("byte_out", want.byte_out, byte_out);
        check_field("is_post", want.is_post, is_post);
        check_field("major_version", want.major, major_version);
        check_field("minor_version", want.minor, minor_version);
        results_seen++;
        if (want.status == STAT_DONE) done_seen++;
        if (want.status == STAT_REJECT) reject_seen++;
        if (want.is_post) post_seen++;
        if (want.major == VER_MAX || want.minor == VER_MAX) sat_seen++;
      end
    end
  end

  // no item moving on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: restart (byte ignored), high byte refused as method start,
    // POST method, high byte taken in the URI, NUL refused there, version
    // line, whitespace before any header refused, blank line completes,
    // a second LF completes again, anything else after is refused.
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h80);
    push_plain("POST ");
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h00);
    push_plain(" HTTP/9.0");
    push_item(1'b0, CH_CR);
    push_item(1'b0, CH_LF);
    push_item(1'b0, CH_SP);
    push_item(1'b0, CH_CR);
    push_item(1'b0, CH_LF);
    push_item(1'b0, CH_LF);
    push_item(1'b0, "a");
    wait_drained();

    // random requests under each pacing mix; each phase ends with the sender
    // paused until every owed result has come back
    run_phase(0, 0, 80, 1'b1);
    run_phase(85, 0, 80, 1'b0);
    run_phase(0, 85, 80, 1'b0);
    run_phase(31, 31, 80, 1'b1);

    repeat (8) @(posedge clk);
    if (parse_results_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, parse_results_q.size());
      error_count++;
    end
    $display("Checked %0d results: %0d header-complete, %0d rejected, %0d with POST method,",
             results_seen, done_seen, reject_seen, post_seen);
    $display("%0d with a saturated version; sender and receiver pacing mixed, %0d errors.",
             sat_seen, error_count);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
